// ===== hw/rtl/afc_pkg.sv =====
// afc_pkg: shared types, widths and register codes for the AABB frustum cull block.
// No dependencies; used by afc_cfg, afc_xform, afc_plane and the top level.
package afc_pkg;

  localparam int unsigned NumCfg     = 8;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CoefW      = 32;              // Q16.16 input and matrix entry
  localparam int unsigned BoundW     = CoefW + 1;       // widened bound, Q17.16
  localparam int unsigned ProdW      = BoundW + CoefW;  // exact product, Q.32
  localparam int unsigned ClipW      = ProdW + 2;       // three products plus translation
  localparam int unsigned TestW      = ClipW + 1;       // sum or difference of two clip values
  localparam int unsigned TransShift = 16;              // Q.16 translation aligned to Q.32
  localparam int unsigned NumAxes    = 3;
  localparam int unsigned NumRows    = 4;
  localparam int unsigned NumCorners = 8;
  localparam int unsigned NumPlanes  = 6;
  localparam int unsigned NumStages  = 5;

  typedef logic signed [CoefW-1:0]  coef_t;
  typedef logic signed [BoundW-1:0] bound_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [ClipW-1:0]  clip_t;
  typedef logic signed [TestW-1:0]  test_t;
  typedef logic [CfgDataW-1:0]      cfg_word_t;

  // One clip-space output row: x, y, z weights and translation
  typedef struct packed {
    coef_t xw;
    coef_t yw;
    coef_t zw;
    coef_t cw;
  } row_coef_t;

  typedef row_coef_t [NumRows-1:0] mat_t;

  // Per-stage advance strobes of the pipeline
  typedef struct packed {
    logic plane_red;   // stage 5: reduce over corners
    logic plane_test;  // stage 4: per-corner plane tests
    logic clip_sum;    // stage 3: clip coordinate sums
    logic mult;        // stage 2: products
    logic bound;       // stage 1: margin widening
  } stage_en_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_X_XY = 3'd0,
    CFG_X_ZC = 3'd1,
    CFG_Y_XY = 3'd2,
    CFG_Y_ZC = 3'd3,
    CFG_Z_XY = 3'd4,
    CFG_Z_ZC = 3'd5,
    CFG_W_XY = 3'd6,
    CFG_W_ZC = 3'd7
  } cfg_idx_e;

  // Row order of the clip coordinates
  localparam int unsigned RowX = 0;
  localparam int unsigned RowY = 1;
  localparam int unsigned RowZ = 2;
  localparam int unsigned RowW = 3;

  // Plane order of the outside tests
  localparam int unsigned PlaneLeft   = 0;  // X < -W
  localparam int unsigned PlaneRight  = 1;  // X >  W
  localparam int unsigned PlaneBottom = 2;  // Y < -W
  localparam int unsigned PlaneTop    = 3;  // Y >  W
  localparam int unsigned PlaneNear   = 4;  // Z <  0
  localparam int unsigned PlaneFar    = 5;  // Z >  W

  localparam cfg_word_t CfgZero    = 64'h0000_0000_0000_0000;
  localparam cfg_word_t CfgOneLow  = 64'h0000_0000_0001_0000;
  localparam cfg_word_t CfgOneHigh = 64'h0001_0000_0000_0000;

endpackage

// ===== hw/rtl/afc_cfg.sv =====
// afc_cfg: matrix register file, eight 64-bit registers with identity reset.
// Depends on afc_pkg.
module afc_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [afc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  afc_pkg::cfg_word_t                cfg_wdata_i,
  output afc_pkg::mat_t                     mat_o
);

  afc_pkg::cfg_word_t cfg_q [afc_pkg::NumCfg];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[afc_pkg::CFG_X_XY] <= afc_pkg::CfgOneLow;
      cfg_q[afc_pkg::CFG_X_ZC] <= afc_pkg::CfgZero;
      cfg_q[afc_pkg::CFG_Y_XY] <= afc_pkg::CfgOneHigh;
      cfg_q[afc_pkg::CFG_Y_ZC] <= afc_pkg::CfgZero;
      cfg_q[afc_pkg::CFG_Z_XY] <= afc_pkg::CfgZero;
      cfg_q[afc_pkg::CFG_Z_ZC] <= afc_pkg::CfgOneLow;
      cfg_q[afc_pkg::CFG_W_XY] <= afc_pkg::CfgZero;
      cfg_q[afc_pkg::CFG_W_ZC] <= afc_pkg::CfgOneHigh;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // low half / high half split of each register pair
  always_comb begin
    for (int r = 0; r < afc_pkg::NumRows; r++) begin
      mat_o[r].xw = afc_pkg::coef_t'(cfg_q[2*r][31:0]);
      mat_o[r].yw = afc_pkg::coef_t'(cfg_q[2*r][63:32]);
      mat_o[r].zw = afc_pkg::coef_t'(cfg_q[2*r+1][31:0]);
      mat_o[r].cw = afc_pkg::coef_t'(cfg_q[2*r+1][63:32]);
    end
  end

endmodule

// ===== hw/rtl/afc_xform.sv =====
// afc_xform: stages 1-3: margin widening, per-axis products, clip sums of 8 corners.
// Depends on afc_pkg.
module afc_xform (
  input  logic               clk_i,
  input  afc_pkg::stage_en_t en_i,
  input  afc_pkg::coef_t     box_min_x_i,
  input  afc_pkg::coef_t     box_min_y_i,
  input  afc_pkg::coef_t     box_min_z_i,
  input  afc_pkg::coef_t     box_max_x_i,
  input  afc_pkg::coef_t     box_max_y_i,
  input  afc_pkg::coef_t     box_max_z_i,
  input  afc_pkg::coef_t     extra_margin_i,
  input  afc_pkg::mat_t      mat_i,
  output afc_pkg::clip_t     clip_o [afc_pkg::NumCorners][afc_pkg::NumRows]
);

  afc_pkg::bound_t lo_q [afc_pkg::NumAxes];
  afc_pkg::bound_t hi_q [afc_pkg::NumAxes];
  afc_pkg::bound_t lo_d [afc_pkg::NumAxes];
  afc_pkg::bound_t hi_d [afc_pkg::NumAxes];

  // [row][axis][0 = low bound, 1 = high bound]
  afc_pkg::prod_t  prod_q [afc_pkg::NumRows][afc_pkg::NumAxes][2];
  afc_pkg::prod_t  prod_d [afc_pkg::NumRows][afc_pkg::NumAxes][2];
  afc_pkg::coef_t  axis_coef [afc_pkg::NumRows][afc_pkg::NumAxes];

  afc_pkg::clip_t  clip_q [afc_pkg::NumCorners][afc_pkg::NumRows];
  afc_pkg::clip_t  clip_d [afc_pkg::NumCorners][afc_pkg::NumRows];

  // Stage 1: widen by margin, one extra bit so nothing wraps
  always_comb begin
    lo_d[0] = afc_pkg::bound_t'(box_min_x_i) - afc_pkg::bound_t'(extra_margin_i);
    lo_d[1] = afc_pkg::bound_t'(box_min_y_i) - afc_pkg::bound_t'(extra_margin_i);
    lo_d[2] = afc_pkg::bound_t'(box_min_z_i) - afc_pkg::bound_t'(extra_margin_i);
    hi_d[0] = afc_pkg::bound_t'(box_max_x_i) + afc_pkg::bound_t'(extra_margin_i);
    hi_d[1] = afc_pkg::bound_t'(box_max_y_i) + afc_pkg::bound_t'(extra_margin_i);
    hi_d[2] = afc_pkg::bound_t'(box_max_z_i) + afc_pkg::bound_t'(extra_margin_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.bound) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // Stage 2: the transform is linear per axis, so 24 products cover all corners
  always_comb begin
    for (int r = 0; r < afc_pkg::NumRows; r++) begin
      axis_coef[r][0] = mat_i[r].xw;
      axis_coef[r][1] = mat_i[r].yw;
      axis_coef[r][2] = mat_i[r].zw;
    end
    for (int r = 0; r < afc_pkg::NumRows; r++) begin
      for (int a = 0; a < afc_pkg::NumAxes; a++) begin
        prod_d[r][a][0] = afc_pkg::prod_t'(lo_q[a]) * afc_pkg::prod_t'(axis_coef[r][a]);
        prod_d[r][a][1] = afc_pkg::prod_t'(hi_q[a]) * afc_pkg::prod_t'(axis_coef[r][a]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mult) begin
      prod_q <= prod_d;
    end
  end

  // Stage 3: corner bit 0 picks x bound, bit 1 y, bit 2 z
  always_comb begin
    for (int c = 0; c < afc_pkg::NumCorners; c++) begin
      for (int r = 0; r < afc_pkg::NumRows; r++) begin
        clip_d[c][r] =
            afc_pkg::clip_t'(((c & 1) != 0) ? prod_q[r][0][1] : prod_q[r][0][0])
          + afc_pkg::clip_t'(((c & 2) != 0) ? prod_q[r][1][1] : prod_q[r][1][0])
          + afc_pkg::clip_t'(((c & 4) != 0) ? prod_q[r][2][1] : prod_q[r][2][0])
          + (afc_pkg::clip_t'(mat_i[r].cw) <<< afc_pkg::TransShift);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.clip_sum) begin
      clip_q <= clip_d;
    end
  end

  assign clip_o = clip_q;

endmodule

// ===== hw/rtl/afc_plane.sv =====
// afc_plane: stages 4-5: six outside tests per corner, then all-corners reduction.
// Depends on afc_pkg.
module afc_plane (
  input  logic               clk_i,
  input  afc_pkg::stage_en_t en_i,
  input  afc_pkg::clip_t     clip_i [afc_pkg::NumCorners][afc_pkg::NumRows],
  output logic               visible_o
);

  logic [afc_pkg::NumPlanes-1:0] out_q [afc_pkg::NumCorners];
  logic [afc_pkg::NumPlanes-1:0] out_d [afc_pkg::NumCorners];
  logic [afc_pkg::NumPlanes-1:0] all_out;
  logic                          visible_q;
  logic                          visible_d;

  always_comb begin
    afc_pkg::test_t x_pw;
    afc_pkg::test_t x_mw;
    afc_pkg::test_t y_pw;
    afc_pkg::test_t y_mw;
    afc_pkg::test_t z_mw;
    for (int c = 0; c < afc_pkg::NumCorners; c++) begin
      x_pw = afc_pkg::test_t'(clip_i[c][afc_pkg::RowX])
           + afc_pkg::test_t'(clip_i[c][afc_pkg::RowW]);
      x_mw = afc_pkg::test_t'(clip_i[c][afc_pkg::RowX])
           - afc_pkg::test_t'(clip_i[c][afc_pkg::RowW]);
      y_pw = afc_pkg::test_t'(clip_i[c][afc_pkg::RowY])
           + afc_pkg::test_t'(clip_i[c][afc_pkg::RowW]);
      y_mw = afc_pkg::test_t'(clip_i[c][afc_pkg::RowY])
           - afc_pkg::test_t'(clip_i[c][afc_pkg::RowW]);
      z_mw = afc_pkg::test_t'(clip_i[c][afc_pkg::RowZ])
           - afc_pkg::test_t'(clip_i[c][afc_pkg::RowW]);
      // strict tests: a corner on a plane counts as inside
      out_d[c][afc_pkg::PlaneLeft]   = x_pw[afc_pkg::TestW-1];
      out_d[c][afc_pkg::PlaneRight]  = !x_mw[afc_pkg::TestW-1] && (|x_mw);
      out_d[c][afc_pkg::PlaneBottom] = y_pw[afc_pkg::TestW-1];
      out_d[c][afc_pkg::PlaneTop]    = !y_mw[afc_pkg::TestW-1] && (|y_mw);
      out_d[c][afc_pkg::PlaneNear]   = clip_i[c][afc_pkg::RowZ][afc_pkg::ClipW-1];
      out_d[c][afc_pkg::PlaneFar]    = !z_mw[afc_pkg::TestW-1] && (|z_mw);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.plane_test) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    all_out = '1;
    for (int c = 0; c < afc_pkg::NumCorners; c++) begin
      all_out = all_out & out_q[c];
    end
    visible_d = ~|all_out;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.plane_red) begin
      visible_q <= visible_d;
    end
  end

  assign visible_o = visible_q;

endmodule

// ===== hw/rtl/aabb_frustum_cull_top.sv =====
// aabb_frustum_cull_top: clip-space AABB frustum cull, five-stage pipeline.
// out_valid_o rises once the box has passed the five register stages, the first loaded on
// the input transaction's edge. Throughput: one box per cycle while out_ready_i is high;
// one 33x32 multiply per matrix entry and bound is the long stage.
// Stalls from the output back-pressure all stages; bubbles are squeezed out.
// Reset (rst_ni low, async): all stage valids clear, matrix returns to identity.
// Depends on afc_pkg, afc_cfg, afc_xform, afc_plane.
module aabb_frustum_cull_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [afc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  afc_pkg::cfg_word_t          cfg_wdata_i,
  // box input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  afc_pkg::coef_t              box_min_x_i,
  input  afc_pkg::coef_t              box_min_y_i,
  input  afc_pkg::coef_t              box_min_z_i,
  input  afc_pkg::coef_t              box_max_x_i,
  input  afc_pkg::coef_t              box_max_y_i,
  input  afc_pkg::coef_t              box_max_z_i,
  input  afc_pkg::coef_t              extra_margin_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        visible_o
);

  afc_pkg::mat_t     mat;
  afc_pkg::clip_t    clip [afc_pkg::NumCorners][afc_pkg::NumRows];
  afc_pkg::stage_en_t stage_en;

  // valid bit per stage; stage 5 is the output register
  logic [afc_pkg::NumStages-1:0] valid_q;
  logic [afc_pkg::NumStages-1:0] valid_d;
  logic [afc_pkg::NumStages-1:0] stage_rdy;
  logic [afc_pkg::NumStages-1:0] valid_in;
  logic [afc_pkg::NumStages-1:0] en_vec;

  // A stage may load when it is empty or its contents move on this cycle.
  // Ready ripples back from the output, so a full pipeline still takes a
  // transaction per cycle while out_ready_i is high.
  always_comb begin
    stage_rdy[afc_pkg::NumStages-1] = !valid_q[afc_pkg::NumStages-1] || out_ready_i;
    for (int s = afc_pkg::NumStages - 2; s >= 0; s--) begin
      stage_rdy[s] = !valid_q[s] || stage_rdy[s+1];
    end
    valid_in[0] = in_valid_i;
    for (int s = 1; s < afc_pkg::NumStages; s++) begin
      valid_in[s] = valid_q[s-1];
    end
    for (int s = 0; s < afc_pkg::NumStages; s++) begin
      en_vec[s]  = stage_rdy[s] && valid_in[s];
      valid_d[s] = stage_rdy[s] ? valid_in[s] : valid_q[s];
    end
  end

  assign stage_en = afc_pkg::stage_en_t'(en_vec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = stage_rdy[0];
  assign out_valid_o = valid_q[afc_pkg::NumStages-1];

  // Matrix registers; the user must write them only while the pipeline is empty, the block does not enforce it
  afc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mat_o       (mat)
  );

  // Stages 1-3: widened bounds, products, clip coordinates of all 8 corners
  afc_xform u_xform (
    .clk_i          (clk_i),
    .en_i           (stage_en),
    .box_min_x_i    (box_min_x_i),
    .box_min_y_i    (box_min_y_i),
    .box_min_z_i    (box_min_z_i),
    .box_max_x_i    (box_max_x_i),
    .box_max_y_i    (box_max_y_i),
    .box_max_z_i    (box_max_z_i),
    .extra_margin_i (extra_margin_i),
    .mat_i          (mat),
    .clip_o         (clip)
  );

  // Stages 4-5: plane tests and the all-corners-outside reduction
  afc_plane u_plane (
    .clk_i     (clk_i),
    .en_i      (stage_en),
    .clip_i    (clip),
    .visible_o (visible_o)
  );

endmodule

// ===== hw/rtl/afc_checker.sv =====
// afc_checker: port-level assertions for aabb_frustum_cull_top, attached by bind.
// Depends on aabb_frustum_cull_top.
module afc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        visible_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(visible_o))
    else $error("result changed while stalled");

  // open output means the pipeline takes a transaction
  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked with output ready");

  // fixed latency when downstream never stalls
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_valid_i && in_ready_o, 5) && $past(rst_ni, 5)
      && $past(out_ready_i, 1) && $past(out_ready_i, 2)
      && $past(out_ready_i, 3) && $past(out_ready_i, 4)
      && $past(rst_ni, 1) && $past(rst_ni, 2)
      && $past(rst_ni, 3) && $past(rst_ni, 4)
    |-> out_valid_o)
    else $error("result missing five cycles after transaction");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind aabb_frustum_cull_top afc_checker u_afc_checker (.*);
